// ----- src/assert_macros.svh -----
// assertion macros used by the checker of the hash core
// no dependencies; every macro samples on the rising edge and is idle in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define OAH_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OAH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/oah_pkg.sv -----
// shared constants and codes for the open-addressing id hash core
// no dependencies; imported by the sequencer, the top level and the checker
`default_nettype none

package oah_pkg;

    localparam int KIND_W   = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int ORDER_W  = 10;
    localparam int M_TDATA_W = 16;

    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int SLOT_COUNT_DEF  = 2048;
    localparam int PROBE_STRIDE    = 317;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

endpackage

`default_nettype wire

// ----- src/open_addressing_id_hash_core.sv -----
// Open-addressing id hash core. Takes one transaction at a time: an insert,
// lookup or clear, chosen by s_tuser, with the 32-bit id in s_tdata. The probe
// chain starts at the id's low bits and steps by 317 over the slot table; each
// probe reads the slot table, and on a lookup each occupied slot adds a read
// of the key store for the key compare. A clear sweeps the slot table one
// entry a cycle. After reset the same sweep runs with s_tready low. The result
// sits in an output register, so the next transaction may be accepted before
// it is taken.
// Depends on oah_pkg, oah_ram and oah_seq.
`default_nettype none

module open_addressing_id_hash_core
    import oah_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [KEY_W-1:0]     s_tdata,   // [31:0] key
    input  wire logic [KIND_W-1:0]    s_tuser,   // [1:0] kind
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata    // [1:0] status, [11:2] order_index
);

    localparam int SLOT_AW = $clog2(SLOT_COUNT);
    localparam int ENT_AW  = $clog2(MAX_ENTRIES);
    localparam int VAL_W   = $clog2(MAX_ENTRIES + 1);

    logic                slot_we;
    logic [SLOT_AW-1:0]  slot_waddr;
    logic [VAL_W-1:0]    slot_wdata;
    logic [SLOT_AW-1:0]  slot_raddr;
    logic [VAL_W-1:0]    slot_rdata;
    logic                key_we;
    logic [ENT_AW-1:0]   key_waddr;
    logic [KEY_W-1:0]    key_wdata;
    logic [ENT_AW-1:0]   key_raddr;
    logic [KEY_W-1:0]    key_rdata;
    logic [STATUS_W-1:0] status;
    logic [ORDER_W-1:0]  order_index;

    oah_seq #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .SLOT_COUNT  (SLOT_COUNT)
    ) u_seq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_key     (s_tdata),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (status),
        .out_order  (order_index),
        .slot_we    (slot_we),
        .slot_waddr (slot_waddr),
        .slot_wdata (slot_wdata),
        .slot_raddr (slot_raddr),
        .slot_rdata (slot_rdata),
        .key_we     (key_we),
        .key_waddr  (key_waddr),
        .key_wdata  (key_wdata),
        .key_raddr  (key_raddr),
        .key_rdata  (key_rdata)
    );

    // slot value is order+1, zero marks an empty slot
    oah_ram #(
        .WIDTH (VAL_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    oah_ram #(
        .WIDTH (KEY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_key_ram (
        .clk   (aclk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

    assign m_tdata = {(M_TDATA_W - ORDER_W - STATUS_W)'(0), order_index, status};

endmodule

`default_nettype wire

// ----- src/oah_ram.sv -----
// generic single-write, single-read memory with registered read data
// no dependencies; used for the slot table and the key store
`default_nettype none

module oah_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- src/oah_seq.sv -----
// probe sequencer of the id hash core: clearing sweep, probe walk, key compare
// depends on oah_pkg; drives the slot table and key store memories
`default_nettype none

module oah_seq
    import oah_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    localparam int SLOT_AW    = $clog2(SLOT_COUNT),
    localparam int ENT_AW     = $clog2(MAX_ENTRIES),
    localparam int VAL_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // request side
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [KIND_W-1:0]   in_kind,
    input  wire logic [KEY_W-1:0]    in_key,
    // result side
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [STATUS_W-1:0] out_status,
    output logic      [ORDER_W-1:0]  out_order,
    // slot table port
    output logic                     slot_we,
    output logic      [SLOT_AW-1:0]  slot_waddr,
    output logic      [VAL_W-1:0]    slot_wdata,
    output logic      [SLOT_AW-1:0]  slot_raddr,
    input  wire logic [VAL_W-1:0]    slot_rdata,
    // key store port
    output logic                     key_we,
    output logic      [ENT_AW-1:0]   key_waddr,
    output logic      [KEY_W-1:0]    key_wdata,
    output logic      [ENT_AW-1:0]   key_raddr,
    input  wire logic [KEY_W-1:0]    key_rdata
);

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SLOT_CHK,
        S_KEY_CHK,
        S_CLEAR,
        S_DONE
    } state_t;

    state_t               state_reg, state_next;
    logic [SLOT_AW-1:0]   h_reg, h_next;
    logic [SLOT_AW-1:0]   n_reg, n_next;      // probe number, or sweep address
    logic [VAL_W-1:0]     count_reg, count_next;
    logic [KEY_W-1:0]     key_reg, key_next;
    logic                 ins_reg, ins_next;
    logic [ENT_AW-1:0]    idx_reg, idx_next;
    logic [STATUS_W-1:0]  res_status_reg, res_status_next;
    logic [ORDER_W-1:0]   res_order_reg, res_order_next;
    logic                 m_valid_reg, m_valid_next;
    logic [STATUS_W-1:0]  m_status_reg, m_status_next;
    logic [ORDER_W-1:0]   m_order_reg, m_order_next;

    logic [SLOT_AW-1:0]   h_adv;
    logic [VAL_W-1:0]     slot_idx;
    logic                 idx_ok;
    logic                 probe_last;

    // shared probe unit: stride step and slot value decode
    assign h_adv      = h_reg + SLOT_AW'(PROBE_STRIDE);
    assign slot_idx   = slot_rdata - VAL_W'(1);
    assign idx_ok     = slot_idx < VAL_W'(MAX_ENTRIES);
    assign probe_last = (n_reg == {SLOT_AW{1'b1}});

    assign slot_raddr = (state_reg == S_IDLE) ? in_key[SLOT_AW-1:0] : h_adv;
    assign key_raddr  = slot_idx[ENT_AW-1:0];
    assign key_waddr  = count_reg[ENT_AW-1:0];
    assign key_wdata  = key_reg;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = m_valid_reg;
    assign out_status = m_status_reg;
    assign out_order  = m_order_reg;

    always_comb begin
        state_next      = state_reg;
        h_next          = h_reg;
        n_next          = n_reg;
        count_next      = count_reg;
        key_next        = key_reg;
        ins_next        = ins_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        res_order_next  = res_order_reg;
        m_valid_next    = m_valid_reg && !out_ready;
        m_status_next   = m_status_reg;
        m_order_next    = m_order_reg;
        slot_we         = 1'b0;
        slot_waddr      = h_reg;
        slot_wdata      = count_reg + VAL_W'(1);
        key_we          = 1'b0;

        unique case (state_reg)
            S_INIT, S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = n_reg;
                slot_wdata = '0;
                n_next     = n_reg + SLOT_AW'(1);
                if (probe_last) begin
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (in_valid) begin
                    key_next        = in_key;
                    h_next          = in_key[SLOT_AW-1:0];
                    n_next          = '0;
                    res_order_next  = '0;
                    unique case (in_kind)
                        KIND_INSERT: begin
                            ins_next = 1'b1;
                            if (count_reg == VAL_W'(MAX_ENTRIES)) begin
                                res_status_next = STATUS_FULL;
                                state_next      = S_DONE;
                            end else begin
                                state_next = S_SLOT_CHK;
                            end
                        end
                        KIND_LOOKUP: begin
                            ins_next   = 1'b0;
                            state_next = S_SLOT_CHK;
                        end
                        KIND_CLEAR: begin
                            count_next      = '0;
                            res_status_next = STATUS_OK;
                            state_next      = S_CLEAR;
                        end
                        default: begin
                            res_status_next = STATUS_MISS;
                            state_next      = S_DONE;
                        end
                    endcase
                end
            end
            S_SLOT_CHK, S_KEY_CHK: begin
                if (state_reg == S_SLOT_CHK && slot_rdata == '0) begin
                    // empty slot ends the chain
                    state_next = S_DONE;
                    if (ins_reg) begin
                        slot_we         = 1'b1;
                        key_we          = 1'b1;
                        count_next      = count_reg + VAL_W'(1);
                        res_status_next = STATUS_OK;
                        res_order_next  = ORDER_W'(count_reg);
                    end else begin
                        res_status_next = STATUS_MISS;
                    end
                end else if (state_reg == S_SLOT_CHK && !ins_reg && idx_ok) begin
                    idx_next   = slot_idx[ENT_AW-1:0];
                    state_next = S_KEY_CHK;
                end else if (state_reg == S_KEY_CHK && key_rdata == key_reg) begin
                    res_status_next = STATUS_OK;
                    res_order_next  = ORDER_W'(idx_reg);
                    state_next      = S_DONE;
                end else if (probe_last) begin
                    res_status_next = ins_reg ? STATUS_FULL : STATUS_MISS;
                    state_next      = S_DONE;
                end else begin
                    h_next     = h_adv;
                    n_next     = n_reg + SLOT_AW'(1);
                    state_next = S_SLOT_CHK;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || out_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_order_next  = res_order_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            n_reg       <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        h_reg          <= h_next;
        key_reg        <= key_next;
        ins_reg        <= ins_next;
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        res_order_reg  <= res_order_next;
        m_status_reg   <= m_status_next;
        m_order_reg    <= m_order_next;
    end

endmodule

`default_nettype wire

// ----- src/oah_checker.sv -----
// port-level checks for the id hash core, attached to the top level by bind
// depends on oah_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module oah_checker
    import oah_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] m_status;
    logic [ORDER_W-1:0]  m_order;
    logic                status_known;

    assign m_status     = m_tdata[STATUS_W-1:0];
    assign m_order      = m_tdata[STATUS_W +: ORDER_W];
    assign status_known = (m_status == STATUS_OK) || (m_status == STATUS_MISS)
                          || (m_status == STATUS_FULL);

    `OAH_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata), "result dropped or changed while stalled")

    `OAH_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready,
        "accepted a second transaction while busy")

    `OAH_ASSERT_NOW(a_status_code, aclk, aresetn, m_tvalid, status_known,
        "undefined status code")

    `OAH_ASSERT_NOW(a_order_zero, aclk, aresetn, m_tvalid && m_status != STATUS_OK,
        m_order == '0, "order index set on a failed transaction")

    `OAH_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid,
        m_tdata[M_TDATA_W-1:STATUS_W+ORDER_W] == '0, "padding bits of result not zero")

endmodule

bind open_addressing_id_hash_core oah_checker u_oah_checker (.*);

`default_nettype wire
